FILE: rtl/assert_macros.svh
// Assertion macros shared by the timestamp validator checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, silent while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/tfv_pkg.sv
// Types, constants and month table for the timestamp field validator
package tfv_pkg;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_YEAR   = 3'd1,
        ERR_MONTH  = 3'd2,
        ERR_DAY    = 3'd3,
        ERR_HOUR   = 3'd4,
        ERR_MINUTE = 3'd5,
        ERR_SECOND = 3'd6,
        ERR_MSEC   = 3'd7
    } t_err_code;

    typedef enum logic {
        FMT_YMD = 1'b0,
        FMT_DOY = 1'b1
    } t_fmt;

    typedef struct packed {
        logic        cmd;
        logic [15:0] year;
        logic [7:0]  month;
        logic [8:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [9:0]  millisecond;
    } t_stamp;

    typedef struct packed {
        logic      valid_res;
        t_err_code error_code;
        logic      leap_year;
    } t_result;

    localparam logic [15:0] YEAR_MIN    = 16'd1000;
    localparam logic [15:0] YEAR_MAX    = 16'd9999;
    localparam logic [7:0]  MONTH_MAX   = 8'd12;
    localparam logic [7:0]  MONTH_FEB   = 8'd2;
    localparam logic [8:0]  DAYS_FEB_LY = 9'd29;
    localparam logic [8:0]  DOY_MAX     = 9'd365;
    localparam logic [8:0]  DOY_MAX_LY  = 9'd366;
    localparam logic [7:0]  HOUR_MAX    = 8'd23;
    localparam logic [7:0]  MINSEC_MAX  = 8'd59;
    localparam logic [9:0]  MSEC_MAX    = 10'd999;

    // 25 is odd: y is a multiple of 25 exactly when y * inverse(25) mod 2^16
    // falls at or below floor((2^16 - 1) / 25)
    localparam logic [15:0] INV25_MOD16 = 16'h5C29;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    function automatic logic [8:0] month_days(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 9'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = 9'd30;
            4'd2:                                       days = 9'd28;
            default:                                    days = 9'd31;
        endcase
        return days;
    endfunction

endpackage

FILE: rtl/tfv_leap.sv
// Gregorian leap-year test by constant-divisor arithmetic
module tfv_leap import tfv_pkg::*; (
    input  logic [15:0] i_year,
    output logic        o_leap
);

    logic [15:0] scaled;
    logic        div25;
    logic        div4;
    logic        div16;

    assign scaled = 16'(i_year * INV25_MOD16);
    assign div25  = (scaled <= DIV25_LIMIT);
    assign div4   = (i_year[1:0] == 2'b00);
    assign div16  = (i_year[3:0] == 4'b0000);
    assign o_leap = (div4 && !div25) || (div16 && div25);

endmodule

FILE: rtl/tfv_check.sv
// Field range checks and first-failure code for one timestamp
module tfv_check import tfv_pkg::*; (
    input  t_stamp  i_stamp,
    output t_result o_result
);

    logic       leap;
    logic       month_bad;
    logic [8:0] limit;
    t_err_code  code;

    tfv_leap u_leap (
        .i_year (i_stamp.year),
        .o_leap (leap)
    );

    assign month_bad = (i_stamp.month == 8'd0) || (i_stamp.month > MONTH_MAX);

    always_comb begin
        if (i_stamp.cmd == FMT_DOY) begin
            limit = leap ? DOY_MAX_LY : DOY_MAX;
        end else if (leap && (i_stamp.month == MONTH_FEB)) begin
            limit = DAYS_FEB_LY;
        end else begin
            limit = month_days(i_stamp.month[3:0]);
        end
    end

    always_comb begin
        priority if ((i_stamp.year < YEAR_MIN) || (i_stamp.year > YEAR_MAX)) begin
            code = ERR_YEAR;
        end else if ((i_stamp.cmd == FMT_YMD) && month_bad) begin
            code = ERR_MONTH;
        end else if ((i_stamp.day == 9'd0) || (i_stamp.day > limit)) begin
            code = ERR_DAY;
        end else if (i_stamp.hour > HOUR_MAX) begin
            code = ERR_HOUR;
        end else if (i_stamp.minute > MINSEC_MAX) begin
            code = ERR_MINUTE;
        end else if (i_stamp.second > MINSEC_MAX) begin
            code = ERR_SECOND;
        end else if (i_stamp.millisecond > MSEC_MAX) begin
            code = ERR_MSEC;
        end else begin
            code = ERR_NONE;
        end
    end

    assign o_result.valid_res  = (code == ERR_NONE);
    assign o_result.error_code = code;
    assign o_result.leap_year  = leap;

endmodule

FILE: rtl/timestamp_field_validator_core.sv
// Top level of the timestamp field validator: input register, checks, result register
//
// Usage:
//   Input channel i_valid / o_ready carries one timestamp per item: format
//   (i_cmd), year, month, day, hour, minute, second and millisecond.
//   Output channel o_valid / i_ready returns one result per item: valid flag,
//   code of the first failing check and the Gregorian leap-year flag.
//   Path: an accepted item is held in the input register while the checks
//   run; its result is captured in the result register once that is free
//   and is shown on o_valid until it is taken.
//   Throughput: one item per cycle while i_ready is high; the checks fit
//   between the two registers, the longest path being the 16 x 16 constant
//   multiply of the divisible-by-25 leap test followed by a compare.
//   Stall: while i_ready is low the result holds; the input register still
//   takes one more item, after which o_ready drops until the result moves.
//   Reset: synchronous, active low; both stages empty, o_ready high after.
//   Items leave in the order they arrive, one result for every item.
module timestamp_field_validator_core import tfv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_year,
    input  logic [7:0]  i_month,
    input  logic [8:0]  i_day,
    input  logic [7:0]  i_hour,
    input  logic [7:0]  i_minute,
    input  logic [7:0]  i_second,
    input  logic [9:0]  i_millisecond,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_valid_res,
    output logic [2:0]  o_error_code,
    output logic        o_leap_year
);

    logic    r_in_valid;
    logic    n_in_valid;
    t_stamp  r_stamp;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result check_res;
    logic    out_ready;
    logic    in_take;

    assign out_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || out_ready;
    assign in_take   = i_valid && o_ready;

    assign n_in_valid  = in_take || (r_in_valid && !out_ready);
    assign n_out_valid = (r_in_valid && out_ready) || (r_out_valid && !i_ready);

    tfv_check u_check (
        .i_stamp  (r_stamp),
        .o_result (check_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_stamp.cmd         <= i_cmd;
            r_stamp.year        <= i_year;
            r_stamp.month       <= i_month;
            r_stamp.day         <= i_day;
            r_stamp.hour        <= i_hour;
            r_stamp.minute      <= i_minute;
            r_stamp.second      <= i_second;
            r_stamp.millisecond <= i_millisecond;
        end
        if (r_in_valid && out_ready) begin
            r_result <= check_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_valid_res  = r_result.valid_res;
    assign o_error_code = r_result.error_code;
    assign o_leap_year  = r_result.leap_year;

endmodule

FILE: rtl/tfv_checker.sv
// Port-level assertions for the timestamp field validator and their bind
`include "assert_macros.svh"

module tfv_checker import tfv_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_valid_res,
    input logic [2:0] o_error_code
);

    `ASSERT_CLK(a_flag_matches_code, i_clk, i_rst_n, o_valid |-> (o_valid_res == (o_error_code == ERR_NONE)), "valid flag disagrees with error code")
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "input stalled while no result waits")
    `ASSERT_CLK(a_result_holds, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_error_code)), "stalled result changed")
    `ASSERT_CLK_ALWAYS(a_reset_empties, i_clk, $past(!i_rst_n) |-> !o_valid, "result shown right after reset")

endmodule

bind timestamp_field_validator_core tfv_checker u_tfv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_valid_res  (o_valid_res),
    .o_error_code (o_error_code)
);

FILE: sim/timestamp_field_validator_core_test.sv
// Testbench for the timestamp field validator: directed table, random items, scoreboard check
module timestamp_field_validator_core_test import tfv_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_stamp  stamp;
        logic    typed;
        t_result want;
    } t_stamp_row;

    typedef struct {
        bit      typed;
        t_result want;
    } t_fixed_result;

    localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int PHASE_ITEMS = 188;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_cmd;
    logic [15:0] i_year;
    logic [7:0]  i_month;
    logic [8:0]  i_day;
    logic [7:0]  i_hour;
    logic [7:0]  i_minute;
    logic [7:0]  i_second;
    logic [9:0]  i_millisecond;
    logic        o_valid;
    logic        i_ready;
    logic        o_valid_res;
    logic [2:0]  o_error_code;
    logic        o_leap_year;

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    t_result       pending_results [$];
    t_fixed_result fixed_results [$];

    t_stamp_row directed_rows [25] = '{
        '{'{FMT_YMD, 2000, 2, 29, 0, 0, 0, 0},          1, '{1, ERR_NONE, 1}},
        '{'{FMT_YMD, 999, 1, 1, 0, 0, 0, 0},            1, '{0, ERR_YEAR, 0}},
        '{'{FMT_YMD, 10000, 1, 1, 0, 0, 0, 0},          1, '{0, ERR_YEAR, 1}},
        '{'{FMT_YMD, 0, 1, 1, 0, 0, 0, 0},              1, '{0, ERR_YEAR, 1}},
        '{'{FMT_YMD, 65535, 6, 15, 12, 30, 30, 500},    1, '{0, ERR_YEAR, 0}},
        '{'{FMT_YMD, 1000, 1, 1, 0, 0, 0, 0},           1, '{1, ERR_NONE, 0}},
        '{'{FMT_YMD, 9999, 12, 31, 23, 59, 59, 999},    1, '{1, ERR_NONE, 0}},
        '{'{FMT_YMD, 2001, 0, 10, 0, 0, 0, 0},          1, '{0, ERR_MONTH, 0}},
        '{'{FMT_YMD, 2001, 13, 10, 0, 0, 0, 0},         1, '{0, ERR_MONTH, 0}},
        '{'{FMT_DOY, 2001, 255, 100, 0, 0, 0, 0},       1, '{1, ERR_NONE, 0}},
        '{'{FMT_YMD, 2001, 5, 0, 0, 0, 0, 0},           1, '{0, ERR_DAY, 0}},
        '{'{FMT_YMD, 1900, 2, 29, 0, 0, 0, 0},          1, '{0, ERR_DAY, 0}},
        '{'{FMT_YMD, 2001, 4, 31, 0, 0, 0, 0},          1, '{0, ERR_DAY, 0}},
        '{'{FMT_DOY, 2000, 0, 366, 0, 0, 0, 0},         1, '{1, ERR_NONE, 1}},
        '{'{FMT_DOY, 2001, 0, 366, 0, 0, 0, 0},         1, '{0, ERR_DAY, 0}},
        '{'{FMT_DOY, 2001, 0, 0, 0, 0, 0, 0},           1, '{0, ERR_DAY, 0}},
        '{'{FMT_DOY, 2004, 0, 511, 0, 0, 0, 0},         1, '{0, ERR_DAY, 1}},
        '{'{FMT_YMD, 2001, 3, 1, 24, 0, 0, 0},          1, '{0, ERR_HOUR, 0}},
        '{'{FMT_YMD, 2001, 3, 1, 23, 60, 0, 0},         1, '{0, ERR_MINUTE, 0}},
        '{'{FMT_YMD, 2001, 3, 1, 23, 59, 60, 0},        1, '{0, ERR_SECOND, 0}},
        '{'{FMT_YMD, 2001, 3, 1, 23, 59, 59, 1000},     1, '{0, ERR_MSEC, 0}},
        '{'{FMT_YMD, 2001, 3, 1, 255, 255, 255, 1023},  1, '{0, ERR_HOUR, 0}},
        '{'{FMT_DOY, 65535, 255, 511, 255, 255, 255, 1023}, 1, '{0, ERR_YEAR, 0}},
        '{'{FMT_YMD, 2024, 2, 29, 7, 45, 12, 345},      0, '{0, ERR_NONE, 0}},
        '{'{FMT_DOY, 2100, 77, 365, 18, 0, 59, 1},      0, '{0, ERR_NONE, 0}}
    };

    timestamp_field_validator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_millisecond (i_millisecond),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_valid_res   (o_valid_res),
        .o_error_code  (o_error_code),
        .o_leap_year   (o_leap_year)
    );

    function automatic logic is_gregorian_leap(input logic [15:0] year);
        int y;
        y = int'(year);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int day_limit(input logic cmd, input logic [7:0] month,
                                     input logic leap);
        if (cmd == FMT_DOY) begin
            return leap ? 366 : 365;
        end
        if (month < 1 || month > MONTH_MAX) begin
            return 31;
        end
        if (leap && month == MONTH_FEB) begin
            return 29;
        end
        return MONTH_LEN[4'(month - 8'd1)];
    endfunction

    function automatic t_result check_timestamp(input t_stamp s);
        t_result r;
        logic    leap;
        int      limit;
        leap = is_gregorian_leap(s.year);
        limit = day_limit(s.cmd, s.month, leap);
        if (s.year < YEAR_MIN || s.year > YEAR_MAX) begin
            r.error_code = ERR_YEAR;
        end else if (s.cmd == FMT_YMD && (s.month < 1 || s.month > MONTH_MAX)) begin
            r.error_code = ERR_MONTH;
        end else if (s.day < 1 || s.day > limit) begin
            r.error_code = ERR_DAY;
        end else if (s.hour > HOUR_MAX) begin
            r.error_code = ERR_HOUR;
        end else if (s.minute > MINSEC_MAX) begin
            r.error_code = ERR_MINUTE;
        end else if (s.second > MINSEC_MAX) begin
            r.error_code = ERR_SECOND;
        end else if (s.millisecond > MSEC_MAX) begin
            r.error_code = ERR_MSEC;
        end else begin
            r.error_code = ERR_NONE;
        end
        r.valid_res = (r.error_code == ERR_NONE);
        r.leap_year = leap;
        return r;
    endfunction

    function automatic t_stamp random_stamp();
        t_stamp s;
        int     pick;
        int     limit;
        s.cmd = 1'($urandom_range(1));
        pick = int'($urandom_range(99));
        if (pick < 6) begin
            s.year = 16'($urandom_range(65535));
        end else if (pick < 10) begin
            case ($urandom_range(3))
                0: s.year = 16'd999;
                1: s.year = 16'd1000;
                2: s.year = 16'd9999;
                default: s.year = 16'd10000;
            endcase
        end else if (pick < 30) begin
            s.year = 16'(400 * $urandom_range(3, 24));
        end else if (pick < 45) begin
            s.year = 16'(100 * $urandom_range(10, 99));
        end else if (pick < 65) begin
            s.year = 16'(4 * $urandom_range(250, 2499));
        end else begin
            s.year = 16'($urandom_range(1000, 9999));
        end
        s.month = 8'(($urandom_range(99) < 8) ? $urandom_range(255) : $urandom_range(1, 12));
        limit = day_limit(s.cmd, s.month, is_gregorian_leap(s.year));
        pick = int'($urandom_range(99));
        if (pick < 8) begin
            s.day = 9'($urandom_range(511));
        end else if (pick < 20) begin
            s.day = 9'(limit);
        end else if (pick < 26) begin
            s.day = 9'(limit + 1);
        end else begin
            s.day = 9'($urandom_range(1, limit));
        end
        pick = int'($urandom_range(99));
        s.hour = 8'((pick < 6) ? $urandom_range(255) : (pick < 12) ? 23 : $urandom_range(23));
        pick = int'($urandom_range(99));
        s.minute = 8'((pick < 6) ? $urandom_range(255) : (pick < 12) ? 59 : $urandom_range(59));
        pick = int'($urandom_range(99));
        s.second = 8'((pick < 6) ? $urandom_range(255) : (pick < 12) ? 59 : $urandom_range(59));
        pick = int'($urandom_range(99));
        s.millisecond = 10'((pick < 6) ? $urandom_range(1023) :
                            (pick < 12) ? 999 : $urandom_range(999));
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic send_stamp(input t_stamp s, input bit typed, input t_result want);
        fixed_results.push_back('{typed, want});
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd         <= s.cmd;
        i_year        <= s.year;
        i_month       <= s.month;
        i_day         <= s.day;
        i_hour        <= s.hour;
        i_minute      <= s.minute;
        i_second      <= s.second;
        i_millisecond <= s.millisecond;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : scoreboard
        t_fixed_result f;
        t_stamp        s;
        t_result       want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                s = '{i_cmd, i_year, i_month, i_day, i_hour, i_minute, i_second,
                      i_millisecond};
                f = fixed_results.pop_front();
                pending_results.push_back(f.typed ? f.want : check_timestamp(s));
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_valid_res !== want.valid_res) begin
                        report_mismatch("valid_res", int'(o_valid_res),
                                        int'(want.valid_res));
                    end
                    if (o_error_code !== want.error_code) begin
                        report_mismatch("error_code", int'(o_error_code),
                                        int'(want.error_code));
                    end
                    if (o_leap_year !== want.leap_year) begin
                        report_mismatch("leap_year", int'(o_leap_year),
                                        int'(want.leap_year));
                    end
                end
            end
        end
    end

    initial begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_result no_result;
        no_result     = '{0, ERR_NONE, 0};
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = FMT_YMD;
        i_year        = '0;
        i_month       = '0;
        i_day         = '0;
        i_hour        = '0;
        i_minute      = '0;
        i_second      = '0;
        i_millisecond = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    send_stamp(directed_rows[i].stamp, directed_rows[i].typed,
                               directed_rows[i].want);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_stamp(random_stamp(), 1'b0, no_result);
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
